// ----- design/dvf_pkg.sv -----
// Package: shared types and constants for the detection vote filter.
`default_nettype none
package dvf_pkg;

  typedef enum logic [1:0] {
    KIND_EMPTY,
    KIND_FIRST,
    KIND_NEXT,
    KIND_CLOSE
  } dvf_kind_t;

  typedef enum logic [1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_RED   = 2'd1,
    VERDICT_GREEN = 2'd2
  } dvf_verdict_t;

  typedef struct packed {
    dvf_kind_t kind;
    logic      last;
  } dvf_ctl_t;

  typedef struct packed {
    logic [2:0]  min_votes;
    logic [9:0]  stop_top_y;
    logic [10:0] stop_right_x;
  } dvf_cfg_t;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 11;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_VOTES    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_TOP_Y   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_RIGHT_X = 2'd2;

  localparam logic [2:0]  MIN_VOTES_RST    = 3'd5;
  localparam logic [9:0]  STOP_TOP_Y_RST   = 10'd65;
  localparam logic [10:0] STOP_RIGHT_X_RST = 11'd485;

endpackage
`default_nettype wire

// ----- design/dvf_if.sv -----
// Interfaces: candidate-box input channel and verdict output channel.
`default_nettype none
interface dvf_item_if #(parameter int COORD_BITS = 10);
  logic                  valid;
  logic                  ready;
  logic                  has_box;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-1:0] box_width;
  logic                  is_green;
  logic                  last_in_frame;

  modport source (output valid, has_box, box_x, box_y, box_width, is_green,
                  last_in_frame, input ready);
  modport sink (input valid, has_box, box_x, box_y, box_width, is_green,
                last_in_frame, output ready);
endinterface

interface dvf_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_verdict;
  logic       red_latched;

  modport source (output valid, frame_verdict, red_latched, input ready);
  modport sink (input valid, frame_verdict, red_latched, output ready);
endinterface
`default_nettype wire

// ----- design/dvf_front.sv -----
// Front end: accepts items, tracks frame boundaries and classifies each box.
`default_nettype none
module dvf_front
  import dvf_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  dvf_item_if.sink                   items,
  input  wire logic                  q_full,
  output logic                       q_push,
  output dvf_ctl_t                   q_ctl,
  output logic [COORD_BITS-1:0]      q_x,
  output logic [COORD_BITS-1:0]      q_y,
  output logic [COORD_BITS-1:0]      q_w,
  output logic                       q_green
);

  logic seen_box;
  logic seen_box_next;
  logic take;

  assign items.ready = !q_full;
  assign take        = items.valid && !q_full;

  always_comb begin
    if (items.has_box) begin
      q_ctl.kind = seen_box ? KIND_NEXT : KIND_FIRST;
    end else begin
      q_ctl.kind = seen_box ? KIND_CLOSE : KIND_EMPTY;
    end
    q_ctl.last = items.last_in_frame;
  end

  // empty items inside a frame carry nothing to the back end
  assign q_push  = take && (items.has_box || items.last_in_frame);
  assign q_x     = items.box_x;
  assign q_y     = items.box_y;
  assign q_w     = items.box_width;
  assign q_green = items.is_green;

  assign seen_box_next = items.last_in_frame ? 1'b0 : (seen_box | items.has_box);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_box <= 1'b0;
    end else if (take) begin
      seen_box <= seen_box_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/dvf_fifo.sv -----
// Two-entry queue between the front and back ends.
`default_nettype none
module dvf_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'(DEPTH));
  assign empty = (count == 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- design/dvf_back.sv -----
// Back end: nearest-box pick, vote windows, verdict and result register.
`default_nettype none
module dvf_back
  import dvf_pkg::*;
#(
  parameter int WINDOW     = 5,
  parameter int COORD_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dvf_cfg_t              cfg,
  input  wire logic                  q_empty,
  input  wire dvf_ctl_t              q_ctl,
  input  wire logic [COORD_BITS-1:0] q_x,
  input  wire logic [COORD_BITS-1:0] q_y,
  input  wire logic [COORD_BITS-1:0] q_w,
  input  wire logic                  q_green,
  output logic                       q_pop,
  dvf_result_if.source               results
);

  localparam int DW   = 2 * COORD_BITS + 1;
  localparam int CNTW = $clog2(WINDOW + 1);
  localparam int CMPW = (CNTW > 3) ? CNTW : 3;
  localparam int YW   = (COORD_BITS > 10) ? COORD_BITS : 10;
  localparam int XW   = (COORD_BITS + 1 > 11) ? COORD_BITS + 1 : 11;

  logic                  have_prev;
  logic [COORD_BITS-1:0] prev_x;
  logic [COORD_BITS-1:0] prev_y;
  logic [DW-1:0]         best_dist;
  logic [COORD_BITS-1:0] best_x;
  logic [COORD_BITS-1:0] best_y;
  logic [COORD_BITS-1:0] best_w;
  logic                  best_green;
  logic [WINDOW-1:0]     red_hist;
  logic [WINDOW-1:0]     green_hist;
  logic [CNTW-1:0]       red_cnt;
  logic [CNTW-1:0]       green_cnt;
  logic [CNTW-1:0]       frames_seen;
  logic                  red_flag;
  logic                  out_valid;
  dvf_verdict_t          out_verdict;

  logic [COORD_BITS-1:0]   dx;
  logic [COORD_BITS-1:0]   dy;
  logic [2*COORD_BITS-1:0] dx2;
  logic [2*COORD_BITS-1:0] dy2;
  logic [DW-1:0]           cur_dist;
  logic                    take;
  logic                    frame_box;
  logic [COORD_BITS-1:0]   pick_x;
  logic [COORD_BITS-1:0]   pick_y;
  logic [COORD_BITS-1:0]   pick_w;
  logic                    pick_green;
  logic                    red_vote;
  logic                    green_vote;
  logic [WINDOW-1:0]       red_hist_next;
  logic [WINDOW-1:0]       green_hist_next;
  logic [CNTW-1:0]         red_cnt_next;
  logic [CNTW-1:0]         green_cnt_next;
  logic [2:0]              need;
  logic                    window_full;
  logic                    red_stop;
  logic                    red_hit;
  logic                    green_hit;
  dvf_verdict_t            verdict_next;
  logic                    red_flag_next;
  logic                    frame_end;

  assign q_pop = !q_empty && (!q_ctl.last || !out_valid || results.ready);
  assign frame_end = q_pop && q_ctl.last;

  assign dx       = (q_x > prev_x) ? q_x - prev_x : prev_x - q_x;
  assign dy       = (q_y > prev_y) ? q_y - prev_y : prev_y - q_y;
  assign dx2      = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
  assign dy2      = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
  assign cur_dist = DW'(dx2) + DW'(dy2);

  always_comb begin
    unique case (q_ctl.kind)
      KIND_FIRST: take = 1'b1;
      KIND_NEXT:  take = have_prev && (cur_dist < best_dist);
      default:    take = 1'b0;
    endcase
  end

  assign frame_box  = (q_ctl.kind != KIND_EMPTY);
  assign pick_x     = take ? q_x : best_x;
  assign pick_y     = take ? q_y : best_y;
  assign pick_w     = take ? q_w : best_w;
  assign pick_green = take ? q_green : best_green;
  assign green_vote = frame_box && pick_green;
  assign red_vote   = frame_box && !pick_green;

  assign red_hist_next   = WINDOW'({red_hist, red_vote});
  assign green_hist_next = WINDOW'({green_hist, green_vote});
  assign red_cnt_next    = red_cnt + CNTW'(red_vote) - CNTW'(red_hist[WINDOW-1]);
  assign green_cnt_next  = green_cnt + CNTW'(green_vote) - CNTW'(green_hist[WINDOW-1]);

  assign need        = (cfg.min_votes == 3'd0) ? 3'd1 : cfg.min_votes;
  assign window_full = (frames_seen == CNTW'(WINDOW));
  assign red_stop    = (YW'(pick_y) < YW'(cfg.stop_top_y))
                    || (XW'(pick_x) + XW'(pick_w) > XW'(cfg.stop_right_x));
  assign red_hit     = CMPW'(red_cnt_next) >= CMPW'(need);
  assign green_hit   = CMPW'(green_cnt_next) >= CMPW'(need);

  always_comb begin
    priority if (window_full && red_hit && frame_box && red_stop) begin
      verdict_next  = VERDICT_RED;
      red_flag_next = 1'b1;
    end else if (window_full && green_hit) begin
      verdict_next  = VERDICT_GREEN;
      red_flag_next = 1'b0;
    end else begin
      verdict_next  = VERDICT_NONE;
      red_flag_next = red_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && take) begin
      best_dist  <= cur_dist;
      best_x     <= q_x;
      best_y     <= q_y;
      best_w     <= q_w;
      best_green <= q_green;
    end
    if (frame_end) begin
      out_verdict <= verdict_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev   <= 1'b0;
      prev_x      <= '0;
      prev_y      <= '0;
      red_hist    <= '0;
      green_hist  <= '0;
      red_cnt     <= '0;
      green_cnt   <= '0;
      frames_seen <= '0;
      red_flag    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (frame_end) begin
        if (frame_box) begin
          have_prev <= 1'b1;
          prev_x    <= pick_x;
          prev_y    <= pick_y;
        end
        red_hist   <= red_hist_next;
        green_hist <= green_hist_next;
        red_cnt    <= red_cnt_next;
        green_cnt  <= green_cnt_next;
        if (!window_full) begin
          frames_seen <= frames_seen + CNTW'(1);
        end
        red_flag  <= red_flag_next;
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid         = out_valid;
  assign results.frame_verdict = out_verdict;
  assign results.red_latched   = red_flag;

endmodule
`default_nettype wire

// ----- design/detection_vote_filter.sv -----
// Top level: detection vote filter with configuration registers.
// A frame's last item passes through the queue; the back end registers its result.
// Throughput: one item per cycle; the front accepts while the queue has room.
// Items that do not end a frame give no result and need no output slot.
// Reset (rst, synchronous): clears vote windows, frame count, previous pick and red flag;
// config registers return to min_votes 5, stop_top_y 65, stop_right_x 485.
`default_nettype none
module detection_vote_filter
  import dvf_pkg::*;
#(
  parameter int WINDOW     = 5,
  parameter int COORD_BITS = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  dvf_item_if.sink                       items,
  dvf_result_if.source                   results,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int QW = $bits(dvf_ctl_t) + 3 * COORD_BITS + 1;

  dvf_cfg_t              cfg;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  dvf_ctl_t              f_ctl;
  logic [COORD_BITS-1:0] f_x;
  logic [COORD_BITS-1:0] f_y;
  logic [COORD_BITS-1:0] f_w;
  logic                  f_green;
  logic [QW-1:0]         q_wdata;
  logic [QW-1:0]         q_rdata;
  dvf_ctl_t              b_ctl;
  logic [COORD_BITS-1:0] b_x;
  logic [COORD_BITS-1:0] b_y;
  logic [COORD_BITS-1:0] b_w;
  logic                  b_green;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_votes    <= MIN_VOTES_RST;
      cfg.stop_top_y   <= STOP_TOP_Y_RST;
      cfg.stop_right_x <= STOP_RIGHT_X_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_VOTES:    cfg.min_votes    <= cfg_data[2:0];
        REG_STOP_TOP_Y:   cfg.stop_top_y   <= cfg_data[9:0];
        REG_STOP_RIGHT_X: cfg.stop_right_x <= cfg_data;
        default: ;
      endcase
    end
  end

  dvf_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_ctl   (f_ctl),
    .q_x     (f_x),
    .q_y     (f_y),
    .q_w     (f_w),
    .q_green (f_green)
  );

  assign q_wdata = {f_ctl, f_x, f_y, f_w, f_green};

  dvf_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {b_ctl, b_x, b_y, b_w, b_green} = q_rdata;

  dvf_back #(
    .WINDOW     (WINDOW),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_ctl   (b_ctl),
    .q_x     (b_x),
    .q_y     (b_y),
    .q_w     (b_w),
    .q_green (b_green),
    .q_pop   (q_pop),
    .results (results)
  );

`ifndef SYNTHESIS
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");

  a_red_sets_flag: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.frame_verdict == VERDICT_RED) |-> results.red_latched)
    else $error("red verdict without latched red flag");

  a_green_clears_flag: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.frame_verdict == VERDICT_GREEN) |-> !results.red_latched)
    else $error("green verdict with latched red flag");

  a_result_from_queue: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> !$past(q_empty))
    else $error("result appeared with no queued transaction");
`endif

endmodule
`default_nettype wire
